/* design/block_stats_min_max_mean_dev_assert.svh */
// Assertion helpers shared by the statistics block.
`ifndef BLOCK_STATS_MIN_MAX_MEAN_DEV_ASSERT_SVH
`define BLOCK_STATS_MIN_MAX_MEAN_DEV_ASSERT_SVH
`ifndef SYNTHESIS
`define BSMM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define BSMM_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define BSMM_ASSERT(lbl, clk, rst, prop)
`define BSMM_ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

/* design/bsmm_pkg.sv */
`default_nettype none
package bsmm_pkg;
   localparam int unsigned DEPTH      = 1024;
   localparam int unsigned ADDR_W     = $clog2(DEPTH);
   localparam int unsigned CNT_W      = ADDR_W + 1;
   localparam int unsigned SAMPLE_W   = 32;
   localparam int unsigned SUM_W      = SAMPLE_W + ADDR_W;
   localparam int unsigned DEV_W      = SAMPLE_W + 1 + ADDR_W;
   localparam int unsigned STEP_W     = $clog2(DEV_W + 1);

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] min_value;
      logic signed [SAMPLE_W-1:0] max_value;
      logic signed [SUM_W-1:0]    sum;
      logic [CNT_W-1:0]           count;
      logic                       overflow;
   } job_type;

   typedef struct packed {
      logic                en;
      logic [ADDR_W-1:0]   addr;
      logic [SAMPLE_W-1:0] data;
   } store_wr_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_MEAN,
      BACK_PASS,
      BACK_DEV,
      BACK_OUT
   } back_state_type;
endpackage
`default_nettype wire

/* design/bsmm_ifs.sv */
`default_nettype none
interface bsmm_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [bsmm_pkg::SAMPLE_W-1:0] sample;
   logic                               last;
   modport source (output valid, output sample, output last, input ready);
   modport sink (input valid, input sample, input last, output ready);
endinterface

interface bsmm_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [31:0]                 min_value;
   logic signed [31:0]                 max_value;
   logic signed [31:0]                 mean_value;
   logic [31:0]                        mean_abs_deviation;
   logic [10:0]                        item_count;
   logic                               overflow;
   modport source (output valid, output min_value, output max_value, output mean_value,
                   output mean_abs_deviation, output item_count, output overflow,
                   input ready);
   modport sink (input valid, input min_value, input max_value, input mean_value,
                 input mean_abs_deviation, input item_count, input overflow,
                 output ready);
endinterface
`default_nettype wire

/* design/bsmm_front.sv */
`default_nettype none
module bsmm_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   bsmm_req_if.sink                   req_chan,
   input  wire logic                  q_full,
   input  wire logic                  release_i,
   output bsmm_pkg::job_type          push_job,
   output logic                       push_valid,
   output bsmm_pkg::store_wr_type     store_wr
);
   logic [bsmm_pkg::CNT_W-1:0]           count_ff, count_in;
   logic signed [bsmm_pkg::SAMPLE_W-1:0] min_ff, min_in, max_ff, max_in, x;
   logic signed [bsmm_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic                                 drop_ff, drop_in, closed_ff;
   logic                                 accept, room, first;

   assign req_chan.ready = !closed_ff && !q_full;
   assign accept = req_chan.valid && req_chan.ready;
   assign x      = req_chan.sample;

   always_comb begin
      room     = count_ff < bsmm_pkg::CNT_W'(bsmm_pkg::DEPTH);
      first    = count_ff == '0;
      count_in = count_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      sum_in   = sum_ff;
      drop_in  = drop_ff;
      if (room) begin
         count_in = count_ff + 1'b1;
         min_in   = (first || x < min_ff) ? x : min_ff;
         max_in   = (first || x > max_ff) ? x : max_ff;
         sum_in   = sum_ff + {{(bsmm_pkg::SUM_W-bsmm_pkg::SAMPLE_W){x[bsmm_pkg::SAMPLE_W-1]}}, x};
      end else begin
         drop_in = 1'b1;
      end
      push_job.min_value = min_in;
      push_job.max_value = max_in;
      push_job.sum       = sum_in;
      push_job.count     = count_in;
      push_job.overflow  = drop_in;
      push_valid         = accept && req_chan.last;
      store_wr.en        = accept && room;
      store_wr.addr      = count_ff[bsmm_pkg::ADDR_W-1:0];
      store_wr.data      = x;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         min_ff    <= '0;
         max_ff    <= '0;
         sum_ff    <= '0;
         drop_ff   <= 1'b0;
         closed_ff <= 1'b0;
      end else begin
         if (accept) begin
            if (req_chan.last) begin
               // The set is closed; the store stays locked until the back end has read it.
               count_ff  <= '0;
               min_ff    <= '0;
               max_ff    <= '0;
               sum_ff    <= '0;
               drop_ff   <= 1'b0;
               closed_ff <= 1'b1;
            end else begin
               count_ff <= count_in;
               min_ff   <= min_in;
               max_ff   <= max_in;
               sum_ff   <= sum_in;
               drop_ff  <= drop_in;
            end
         end
         if (release_i) begin
            closed_ff <= 1'b0;
         end
      end
   end
endmodule
`default_nettype wire

/* design/bsmm_queue.sv */
`default_nettype none
module bsmm_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  bsmm_pkg::job_type      push_job,
   input  wire logic              pop,
   output bsmm_pkg::job_type      head,
   output logic                   empty,
   output logic                   full
);
   bsmm_pkg::job_type slot_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        fill_ff;

   assign head  = slot_ff[rd_ptr_ff];
   assign empty = fill_ff == 2'd0;
   assign full  = fill_ff == 2'd2;

   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push && !full) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop && !empty) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         case ({push && !full, pop && !empty})
            2'b10:   fill_ff <= fill_ff + 2'd1;
            2'b01:   fill_ff <= fill_ff - 2'd1;
            default: fill_ff <= fill_ff;
         endcase
      end
   end
endmodule
`default_nettype wire

/* design/bsmm_div.sv */
`default_nettype none
module bsmm_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [bsmm_pkg::DEV_W-1:0] dividend,
   input  wire logic [bsmm_pkg::CNT_W-1:0] divisor,
   output logic                            busy,
   output logic                            done,
   output logic [bsmm_pkg::DEV_W-1:0]      quotient
);
   logic [bsmm_pkg::DEV_W-1:0]  quo_ff;
   logic [bsmm_pkg::CNT_W-1:0]  rem_ff, divisor_ff, rem_in;
   logic [bsmm_pkg::CNT_W:0]    shifted;
   logic [bsmm_pkg::STEP_W-1:0] step_ff;
   logic                        busy_ff, done_ff, ge;

   // Restoring division, one quotient bit per cycle.
   always_comb begin
      shifted = {rem_ff, quo_ff[bsmm_pkg::DEV_W-1]};
      ge      = shifted >= {1'b0, divisor_ff};
      rem_in  = ge ? bsmm_pkg::CNT_W'(shifted - {1'b0, divisor_ff})
                   : bsmm_pkg::CNT_W'(shifted);
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff     <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[bsmm_pkg::DEV_W-2:0], ge};
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= bsmm_pkg::STEP_W'(bsmm_pkg::DEV_W);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == bsmm_pkg::STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
endmodule
`default_nettype wire

/* design/bsmm_back.sv */
`default_nettype none
`include "block_stats_min_max_mean_dev_assert.svh"
module bsmm_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  bsmm_pkg::job_type          head,
   input  wire logic                  q_empty,
   output logic                       pop_o,
   input  bsmm_pkg::store_wr_type     store_wr,
   output logic                       release_o,
   bsmm_rsp_if.source                 rsp_chan
);
   bsmm_pkg::back_state_type             state_ff, state_in;
   bsmm_pkg::job_type                    job_ff;
   logic [bsmm_pkg::SAMPLE_W-1:0]        store_ff [bsmm_pkg::DEPTH];
   logic [bsmm_pkg::SAMPLE_W-1:0]        rd_data_ff;
   logic                                 rd_pend_ff;
   logic [bsmm_pkg::CNT_W-1:0]           idx_ff;
   logic signed [bsmm_pkg::SAMPLE_W-1:0] mean_ff;
   logic                                 neg_ff;
   logic [bsmm_pkg::DEV_W-1:0]           dev_ff;
   logic                                 rsp_valid_ff;
   logic signed [31:0]                   min_out_ff, max_out_ff, mean_out_ff;
   logic [31:0]                          dev_out_ff;
   logic [10:0]                          count_out_ff;
   logic                                 ovf_out_ff;
   logic                                 div_start, div_busy, div_done, load_out, issue;
   logic [bsmm_pkg::DEV_W-1:0]           div_dividend, div_quot;
   logic [bsmm_pkg::CNT_W-1:0]           div_divisor;
   logic [bsmm_pkg::SUM_W-1:0]           abs_sum;
   logic signed [bsmm_pkg::SAMPLE_W:0]   diff;
   logic [bsmm_pkg::SAMPLE_W:0]          abs_diff;
   logic [bsmm_pkg::SAMPLE_W-1:0]        q_low;

   bsmm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         store_ff[store_wr.addr] <= store_wr.data;
      end
      rd_data_ff <= store_ff[idx_ff[bsmm_pkg::ADDR_W-1:0]];
   end

   always_comb begin
      abs_sum  = head.sum[bsmm_pkg::SUM_W-1] ? (~head.sum + 1'b1) : head.sum;
      diff     = {rd_data_ff[bsmm_pkg::SAMPLE_W-1], rd_data_ff}
               - {mean_ff[bsmm_pkg::SAMPLE_W-1], mean_ff};
      abs_diff = diff[bsmm_pkg::SAMPLE_W] ? (~diff + 1'b1) : diff;
      q_low    = div_quot[bsmm_pkg::SAMPLE_W-1:0];
      issue    = (state_ff == bsmm_pkg::BACK_PASS) && (idx_ff < job_ff.count);
   end

   always_comb begin
      state_in     = state_ff;
      pop_o        = 1'b0;
      div_start    = 1'b0;
      div_dividend = dev_ff;
      div_divisor  = job_ff.count;
      release_o    = 1'b0;
      load_out     = 1'b0;
      unique case (state_ff)
         bsmm_pkg::BACK_IDLE: begin
            if (!q_empty) begin
               pop_o        = 1'b1;
               div_start    = 1'b1;
               div_dividend = bsmm_pkg::DEV_W'(abs_sum);
               div_divisor  = head.count;
               state_in     = bsmm_pkg::BACK_MEAN;
            end
         end
         bsmm_pkg::BACK_MEAN: begin
            if (div_done) begin
               state_in = bsmm_pkg::BACK_PASS;
            end
         end
         bsmm_pkg::BACK_PASS: begin
            // Done once every entry has been read and its last read has been summed.
            if (idx_ff == job_ff.count && !rd_pend_ff) begin
               release_o = 1'b1;
               div_start = 1'b1;
               state_in  = bsmm_pkg::BACK_DEV;
            end
         end
         bsmm_pkg::BACK_DEV: begin
            if (div_done) begin
               state_in = bsmm_pkg::BACK_OUT;
            end
         end
         bsmm_pkg::BACK_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_out = 1'b1;
               state_in = bsmm_pkg::BACK_IDLE;
            end
         end
         default: state_in = bsmm_pkg::BACK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsmm_pkg::BACK_IDLE;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= issue;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop_o) begin
         job_ff <= head;
         neg_ff <= head.sum[bsmm_pkg::SUM_W-1];
      end
      if (state_ff == bsmm_pkg::BACK_MEAN && div_done) begin
         mean_ff <= neg_ff ? (~q_low + 1'b1) : q_low;
         idx_ff  <= '0;
         dev_ff  <= '0;
      end else begin
         if (issue) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (rd_pend_ff) begin
            dev_ff <= dev_ff + bsmm_pkg::DEV_W'(abs_diff);
         end
      end
      if (load_out) begin
         min_out_ff   <= job_ff.min_value;
         max_out_ff   <= job_ff.max_value;
         mean_out_ff  <= mean_ff;
         dev_out_ff   <= q_low;
         count_out_ff <= job_ff.count;
         ovf_out_ff   <= job_ff.overflow;
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.min_value          = min_out_ff;
   assign rsp_chan.max_value          = max_out_ff;
   assign rsp_chan.mean_value         = mean_out_ff;
   assign rsp_chan.mean_abs_deviation = dev_out_ff;
   assign rsp_chan.item_count         = count_out_ff;
   assign rsp_chan.overflow           = ovf_out_ff;

   `BSMM_ASSERT(a_idx_bound, clock, reset, (state_ff == bsmm_pkg::BACK_PASS) |-> (idx_ff <= job_ff.count))
   `BSMM_ASSERT_NEVER(a_start_busy, clock, reset, div_start && div_busy)
   `BSMM_ASSERT(a_release_dev, clock, reset, release_o |=> (state_ff == bsmm_pkg::BACK_DEV))
   `BSMM_ASSERT(a_job_count, clock, reset, pop_o |-> (head.count != '0))
endmodule
`default_nettype wire

/* design/block_stats_min_max_mean_dev.sv */
// Set statistics: minimum, maximum, mean and mean absolute deviation.
// The req channel carries one signed Q15.16 sample per word; a word with last
// set closes the set. Words are taken one per cycle while a set loads and the
// job queue has room, and up to 1024 samples are kept; later ones are dropped
// and flagged in overflow. After the closing word the back end divides the sum
// by the count on the shared one-bit-per-cycle divider, reads the sample
// memory once at one entry per cycle, then divides the deviation total.
// The req channel stays stalled from the closing word until the back end has
// finished reading the memory; the next set then loads while the deviation
// division and the output wait run. One result word waits in an output
// register; a stalled receiver holds it, and the back end waits behind it.
// Reset, synchronous and active high, empties the queue and clears the
// front-end accumulators and the control flags; the sample memory and the
// data and output registers are not cleared.
`default_nettype none
module block_stats_min_max_mean_dev (
   input wire logic   clock,
   input wire logic   reset,
   bsmm_req_if.sink   req_chan,
   bsmm_rsp_if.source rsp_chan
);
   bsmm_pkg::job_type      push_job, head;
   bsmm_pkg::store_wr_type store_wr;
   logic                   push_valid, pop, q_empty, q_full, release_sig;

   bsmm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .q_full     (q_full),
      .release_i  (release_sig),
      .push_job   (push_job),
      .push_valid (push_valid),
      .store_wr   (store_wr)
   );

   bsmm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .empty    (q_empty),
      .full     (q_full)
   );

   bsmm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_empty   (q_empty),
      .pop_o     (pop),
      .store_wr  (store_wr),
      .release_o (release_sig),
      .rsp_chan  (rsp_chan)
   );
endmodule
`default_nettype wire
